@@ rtl/phbf_pkg.sv @@
// Shared types, operation codes and saturating helpers of the perturbed
// harmonic bond force block. No dependencies.
`default_nettype none

package phbf_pkg;

  localparam logic [2:0] OP_BOND        = 3'd0;
  localparam logic [2:0] OP_READ_FORCE  = 3'd1;
  localparam logic [2:0] OP_READ_ENERGY = 3'd2;
  localparam logic [2:0] OP_READ_VIRIAL = 3'd3;
  localparam logic [2:0] OP_CLEAR       = 3'd4;

  localparam logic [16:0] LAMBDA_ONE   = 17'h10000;
  localparam logic [11:0] VIRIAL_ROWS  = 12'd3;

  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [47:0] S48_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] S48_MIN = 48'sh8000_0000_0000;

  typedef enum logic [1:0] {
    SH_16,
    SH_17,
    SH_24,
    SH_30
  } phbf_shift_t;

  typedef struct packed {
    logic [2:0]         operation;
    logic [11:0]        atom_first;
    logic [11:0]        atom_second;
    logic [3:0]         energy_group;
    logic signed [31:0] disp_x;
    logic signed [31:0] disp_y;
    logic signed [31:0] disp_z;
    logic [31:0]        stiffness_a;
    logic [31:0]        stiffness_b;
    logic [30:0]        rest_a;
    logic [30:0]        rest_b;
    logic [11:0]        read_index;
  } phbf_item_t;

  typedef struct packed {
    logic signed [63:0] value_x;
    logic signed [63:0] value_y;
    logic signed [63:0] value_z;
    logic signed [63:0] value_energy;
    logic signed [63:0] value_derivative;
  } phbf_result_t;

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? S64_MIN : S64_MAX;
    end
    return s[63:0];
  endfunction

  function automatic logic signed [47:0] add_force48(input logic signed [47:0] old,
                                                      input logic signed [63:0] f);
    logic signed [64:0] s;
    logic signed [64:0] hi;
    logic signed [64:0] lo;
    s  = {{17{old[47]}}, old} + {f[63], f};
    hi = {{17{S48_MAX[47]}}, S48_MAX};
    lo = {{17{S48_MIN[47]}}, S48_MIN};
    if (s > hi) begin
      return S48_MAX;
    end
    if (s < lo) begin
      return S48_MIN;
    end
    return s[47:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/phbf_stream_if.sv @@
// Valid/ready stream channel carrying one payload beat per handshake.
// The payload type is given by the instantiating level.
`default_nettype none

interface phbf_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ rtl/phbf_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module phbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/phbf_mul.sv @@
// Shared 64x64 signed multiply with rounding shift and saturation, built from
// four registered 32x32 partial products. Depends on phbf_pkg.
`default_nettype none

module phbf_mul (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [63:0]  a,
  input  logic signed [63:0]  b,
  input  phbf_pkg::phbf_shift_t shift,
  output logic                done,
  output logic signed [63:0]  result
);
  import phbf_pkg::*;

  logic        busy;
  logic [2:0]  phase;
  logic        neg;
  logic [63:0] ua;
  logic [63:0] ub;
  logic [63:0] pp;
  logic [1:0]  pp_pos;
  logic [127:0] acc;
  phbf_shift_t sh;

  logic [31:0]  op_a;
  logic [31:0]  op_b;
  logic [1:0]   pos;
  logic [127:0] pp_wide;
  logic [127:0] shifted;
  logic [63:0]  mag;

  always_comb begin
    case (phase[1:0])
      2'd0: begin
        op_a = ua[31:0];
        op_b = ub[31:0];
        pos  = 2'd0;
      end
      2'd1: begin
        op_a = ua[31:0];
        op_b = ub[63:32];
        pos  = 2'd1;
      end
      2'd2: begin
        op_a = ua[63:32];
        op_b = ub[31:0];
        pos  = 2'd1;
      end
      default: begin
        op_a = ua[63:32];
        op_b = ub[63:32];
        pos  = 2'd2;
      end
    endcase
  end

  always_comb begin
    case (pp_pos)
      2'd0:    pp_wide = {64'd0, pp};
      2'd1:    pp_wide = {32'd0, pp, 32'd0};
      default: pp_wide = {pp, 64'd0};
    endcase
  end

  always_comb begin
    case (sh)
      SH_16:   shifted = acc >> 16;
      SH_17:   shifted = acc >> 17;
      SH_24:   shifted = acc >> 24;
      default: shifted = acc >> 30;
    endcase
    mag = (|shifted[127:63]) ? 64'h7FFF_FFFF_FFFF_FFFF : {1'b0, shifted[62:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= 3'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        phase <= 3'd0;
      end else if (busy) begin
        phase <= phase + 3'd1;
        if (phase == 3'd5) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= a[63] ^ b[63];
      ua  <= a[63] ? (~a + 64'd1) : a;
      ub  <= b[63] ? (~b + 64'd1) : b;
      sh  <= shift;
      case (shift)
        SH_16:   acc <= 128'h1 << 15;
        SH_17:   acc <= 128'h1 << 16;
        SH_24:   acc <= 128'h1 << 23;
        default: acc <= 128'h1 << 29;
      endcase
    end else if (busy) begin
      if (phase < 3'd4) begin
        pp     <= op_a * op_b;
        pp_pos <= pos;
      end
      if (phase >= 3'd1 && phase <= 3'd4) begin
        acc <= acc + pp_wide;
      end
      if (phase == 3'd5) begin
        result <= neg ? -$signed(mag) : $signed(mag);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/phbf_isqrt.sv @@
// Bit-serial integer square root of a 64-bit value, one result bit per cycle.
// No dependencies.
`default_nettype none

module phbf_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] x,
  output logic        done,
  output logic [31:0] root
);

  logic        busy;
  logic [63:0] rem;
  logic [63:0] res;
  logic [63:0] one;
  logic [63:0] trial;

  assign trial = res + one;
  assign root  = res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && one == 64'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= x;
      res <= 64'd0;
      one <= 64'h4000_0000_0000_0000;
    end else if (busy) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        res <= (res >> 1) + one;
      end else begin
        res <= res >> 1;
      end
      one <= one >> 2;
    end
  end

endmodule

`default_nettype wire

@@ rtl/phbf_div.sv @@
// Three-lane restoring divider for the unit vector: q = (mag << 30) / d, one
// quotient bit per lane per cycle. Relies on mag <= d. No dependencies.
`default_nettype none

module phbf_div (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [2:0][31:0] mag,
  input  logic [31:0]      divisor,
  output logic             done,
  output logic [2:0][30:0] quot
);

  logic             busy;
  logic [4:0]       cnt;
  logic [2:0][31:0] rem;
  logic [2:0][30:0] nb;
  logic [2:0][30:0] q;
  logic [2:0][32:0] trial;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      trial[k] = {rem[k], nb[k][30]};
    end
  end

  assign quot = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 5'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd30) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (start) begin
        rem[k] <= {1'b0, mag[k][31:1]};
        nb[k]  <= {mag[k][0], 30'd0};
      end else if (busy) begin
        if (trial[k] >= {1'b0, divisor}) begin
          rem[k] <= 32'(trial[k] - {1'b0, divisor});
          q[k]   <= {q[k][29:0], 1'b1};
        end else begin
          rem[k] <= trial[k][31:0];
          q[k]   <= {q[k][29:0], 1'b0};
        end
        nb[k] <= nb[k] << 1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/perturbed_harmonic_bond_force_top.sv @@
// Perturbed harmonic bond force accumulator: per-atom forces and per-group
// energy/lambda-derivative sums in RAM, virial in flops. Depends on phbf_pkg,
// phbf_stream_if, phbf_ram, phbf_mul, phbf_isqrt, phbf_div.
//
// One item is worked at a time. A bond beat is a 32-step square root, a 31-step
// three-lane divider for the unit vector (skipped for a zero length), eighteen
// passes through the one shared 64x64 multiplier, then read-modify-write of the
// group entry and of the two atom entries in the force RAM. A read beat goes
// through S_GRD to S_RRESP, which waits while an earlier result is unread; its
// result then waits in an output register while the next beat is taken. Clear,
// and reset, sweep max(ATOM_COUNT, GROUP_COUNT) RAM entries, one entry per
// cycle, with no beat accepted; configuration writes are taken at any time.
`default_nettype none

module perturbed_harmonic_bond_force_top #(
  parameter int ATOM_COUNT  = 4096,
  parameter int GROUP_COUNT = 16
) (
  input  logic               clk,
  input  logic               rst,
  phbf_stream_if.sink        item,
  phbf_stream_if.source      result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import phbf_pkg::*;

  localparam int AW        = $clog2(ATOM_COUNT);
  localparam int GW        = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
  localparam int CLR_DEPTH = (ATOM_COUNT > GROUP_COUNT) ? ATOM_COUNT : GROUP_COUNT;
  localparam int CW        = $clog2(CLR_DEPTH);

  localparam logic REG_LAMBDA = 1'b0;
  localparam logic REG_SLOPE  = 1'b1;

  localparam logic [4:0] MS_M   = 5'd0;
  localparam logic [4:0] MS_FX  = 5'd1;
  localparam logic [4:0] MS_FY  = 5'd2;
  localparam logic [4:0] MS_FZ  = 5'd3;
  localparam logic [4:0] MS_DSQ = 5'd13;
  localparam logic [4:0] MS_E   = 5'd14;
  localparam logic [4:0] MS_T1  = 5'd15;
  localparam logic [4:0] MS_T2  = 5'd16;
  localparam logic [4:0] MS_EL  = 5'd17;

  typedef enum logic [14:0] {
    S_IDLE   = 15'b000000000000001,
    S_CLEAR  = 15'b000000000000010,
    S_PREP   = 15'b000000000000100,
    S_SUM    = 15'b000000000001000,
    S_SQRT   = 15'b000000000010000,
    S_DIVGO  = 15'b000000000100000,
    S_DIV    = 15'b000000001000000,
    S_MUL    = 15'b000000010000000,
    S_GRD    = 15'b000000100000000,
    S_GWR    = 15'b000001000000000,
    S_FRD_I  = 15'b000010000000000,
    S_FWR_I  = 15'b000100000000000,
    S_FRD_J  = 15'b001000000000000,
    S_FWR_J  = 15'b010000000000000,
    S_RRESP  = 15'b100000000000000
  } state_t;

  state_t state;
  logic [CW-1:0] clr_cnt;

  logic [16:0]        lambda;
  logic signed [31:0] lambda_slope;
  logic [16:0]        lam_eff;

  phbf_item_t itm;
  logic signed [31:0] v [3];
  logic [2:0][31:0]   vmag;

  logic [63:0] sq [3];
  logic [48:0] bl_k0, bl_k1;
  logic [47:0] bl_r0, bl_r1;
  logic [49:0] ksum;
  logic [48:0] rsum;
  logic [31:0] stiff;
  logic [30:0] rest;
  logic [31:0] dlen;
  logic signed [32:0] diff;
  logic signed [31:0] u [3];
  logic signed [63:0] m, dsq, e_term, t1, t2, el_term;
  logic signed [63:0] f [3];
  logic signed [63:0] virial [3][3];
  logic [1:0] vrow, vcol;
  logic [4:0] step;
  logic       issued;

  logic               mul_start, mul_done;
  logic signed [63:0] mul_a, mul_b, mul_res;
  phbf_shift_t        mul_sh;

  logic        sq_start, sq_done;
  logic [31:0] sq_root;
  logic        div_start, div_done;
  logic [2:0][30:0] div_q;

  logic              f_we;
  logic [AW-1:0]     f_waddr, f_raddr;
  logic [143:0]      f_wdata, f_rdata;
  logic              g_we;
  logic [GW-1:0]     g_waddr, g_raddr;
  logic [127:0]      g_wdata, g_rdata;

  logic ai_ok, aj_ok, gi_ok, ri_atom_ok, ri_group_ok, ri_vir_ok;
  logic cfg_wr;

  logic               res_valid;
  phbf_result_t       res_data;
  phbf_result_t       res_next;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_SLOPE) ? lambda_slope : {15'd0, lambda};

  always_ff @(posedge clk) begin
    if (rst) begin
      lambda       <= 17'd0;
      lambda_slope <= 32'sd65536;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_LAMBDA) begin
        lambda <= pwdata[16:0];
      end else begin
        lambda_slope <= pwdata;
      end
    end
  end

  assign lam_eff = (lambda > LAMBDA_ONE) ? LAMBDA_ONE : lambda;

  assign v[0] = itm.disp_x;
  assign v[1] = itm.disp_y;
  assign v[2] = itm.disp_z;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      vmag[k] = v[k][31] ? (~v[k] + 32'd1) : v[k];
    end
  end

  assign ai_ok       = {5'd0, itm.atom_first} < 17'(ATOM_COUNT);
  assign aj_ok       = {5'd0, itm.atom_second} < 17'(ATOM_COUNT);
  assign gi_ok       = 9'(itm.energy_group) < 9'(GROUP_COUNT);
  assign ri_atom_ok  = {5'd0, itm.read_index} < 17'(ATOM_COUNT);
  assign ri_group_ok = 13'(itm.read_index) < 13'(GROUP_COUNT);
  assign ri_vir_ok   = itm.read_index < VIRIAL_ROWS;

  assign ksum = 50'(bl_k0) + 50'(bl_k1) + 50'd32768;
  assign rsum = 49'(bl_r0) + 49'(bl_r1) + 49'd32768;

  // Arithmetic units
  assign sq_start  = (state == S_SUM);
  assign div_start = (state == S_DIVGO) && (dlen != 32'd0);
  assign mul_start = (state == S_MUL) && !issued;

  phbf_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .x     (sq[0] + sq[1] + sq[2]),
    .done  (sq_done),
    .root  (sq_root)
  );

  phbf_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .mag     (vmag),
    .divisor (dlen),
    .done    (div_done),
    .quot    (div_q)
  );

  phbf_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .shift  (mul_sh),
    .done   (mul_done),
    .result (mul_res)
  );

  always_comb begin
    case (step)
      MS_M: begin
        mul_a  = {32'd0, stiff};
        mul_b  = {{31{diff[32]}}, diff};
        mul_sh = SH_16;
      end
      MS_FX: begin
        mul_a  = m;
        mul_b  = {{32{u[0][31]}}, u[0]};
        mul_sh = SH_30;
      end
      MS_FY: begin
        mul_a  = m;
        mul_b  = {{32{u[1][31]}}, u[1]};
        mul_sh = SH_30;
      end
      MS_FZ: begin
        mul_a  = m;
        mul_b  = {{32{u[2][31]}}, u[2]};
        mul_sh = SH_30;
      end
      MS_DSQ: begin
        mul_a  = {{31{diff[32]}}, diff};
        mul_b  = {{31{diff[32]}}, diff};
        mul_sh = SH_24;
      end
      MS_E: begin
        mul_a  = {32'd0, stiff};
        mul_b  = dsq;
        mul_sh = SH_17;
      end
      MS_T1: begin
        mul_a  = 64'($signed({1'b0, itm.stiffness_b}) - $signed({1'b0, itm.stiffness_a}));
        mul_b  = dsq;
        mul_sh = SH_17;
      end
      MS_T2: begin
        mul_a  = m;
        mul_b  = 64'($signed({1'b0, itm.rest_b}) - $signed({1'b0, itm.rest_a}));
        mul_sh = SH_24;
      end
      MS_EL: begin
        mul_a  = {{32{lambda_slope[31]}}, lambda_slope};
        mul_b  = sat_add64(t1, -t2);
        mul_sh = SH_16;
      end
      default: begin
        mul_a  = {{32{v[vrow][31]}}, v[vrow]};
        mul_b  = f[vcol];
        mul_sh = SH_24;
      end
    endcase
  end

  // Memories
  always_comb begin
    f_we    = 1'b0;
    f_waddr = AW'(itm.atom_first);
    f_wdata = {add_force48($signed(f_rdata[143:96]), f[0]),
               add_force48($signed(f_rdata[95:48]), f[1]),
               add_force48($signed(f_rdata[47:0]), f[2])};
    g_we    = 1'b0;
    g_waddr = GW'(itm.energy_group);
    g_wdata = {sat_add64($signed(g_rdata[127:64]), e_term),
               sat_add64($signed(g_rdata[63:0]), el_term)};
    f_raddr = AW'(itm.read_index);
    g_raddr = GW'(itm.read_index);
    unique case (state)
      S_CLEAR: begin
        f_we    = {1'b0, clr_cnt} < (CW+1)'(ATOM_COUNT);
        f_waddr = AW'(clr_cnt);
        f_wdata = '0;
        g_we    = {1'b0, clr_cnt} < (CW+1)'(GROUP_COUNT);
        g_waddr = GW'(clr_cnt);
        g_wdata = '0;
      end
      S_GRD: begin
        if (itm.operation == OP_BOND) begin
          g_raddr = GW'(itm.energy_group);
        end
      end
      S_GWR: begin
        g_raddr = GW'(itm.energy_group);
        g_we    = gi_ok;
      end
      S_FRD_I: begin
        f_raddr = AW'(itm.atom_first);
      end
      S_FWR_I: begin
        f_raddr = AW'(itm.atom_first);
        f_we    = ai_ok;
      end
      S_FRD_J: begin
        f_raddr = AW'(itm.atom_second);
      end
      S_FWR_J: begin
        f_raddr = AW'(itm.atom_second);
        f_waddr = AW'(itm.atom_second);
        f_we    = aj_ok;
        f_wdata = {add_force48($signed(f_rdata[143:96]), -f[0]),
                   add_force48($signed(f_rdata[95:48]), -f[1]),
                   add_force48($signed(f_rdata[47:0]), -f[2])};
      end
      default: begin
      end
    endcase
  end

  phbf_ram #(.WIDTH(144), .DEPTH(ATOM_COUNT)) u_force_ram (
    .clk   (clk),
    .we    (f_we),
    .waddr (f_waddr),
    .wdata (f_wdata),
    .raddr (f_raddr),
    .rdata (f_rdata)
  );

  phbf_ram #(.WIDTH(128), .DEPTH(GROUP_COUNT)) u_group_ram (
    .clk   (clk),
    .we    (g_we),
    .waddr (g_waddr),
    .wdata (g_wdata),
    .raddr (g_raddr),
    .rdata (g_rdata)
  );

  // Result assembly
  always_comb begin
    res_next = '0;
    case (itm.operation)
      OP_READ_FORCE: begin
        if (ri_atom_ok) begin
          res_next.value_x = {{16{f_rdata[143]}}, f_rdata[143:96]};
          res_next.value_y = {{16{f_rdata[95]}}, f_rdata[95:48]};
          res_next.value_z = {{16{f_rdata[47]}}, f_rdata[47:0]};
        end
      end
      OP_READ_ENERGY: begin
        if (ri_group_ok) begin
          res_next.value_energy     = g_rdata[127:64];
          res_next.value_derivative = g_rdata[63:0];
        end
      end
      default: begin
        if (ri_vir_ok) begin
          res_next.value_x = virial[itm.read_index[1:0]][0];
          res_next.value_y = virial[itm.read_index[1:0]][1];
          res_next.value_z = virial[itm.read_index[1:0]][2];
        end
      end
    endcase
  end

  assign item.ready     = (state == S_IDLE);
  assign result.valid   = res_valid;
  assign result.payload = res_data;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      res_valid <= 1'b0;
      issued    <= 1'b0;
      step      <= 5'd0;
      vrow      <= 2'd0;
      vcol      <= 2'd0;
      for (int a = 0; a < 3; a++) begin
        for (int b = 0; b < 3; b++) begin
          virial[a][b] <= 64'sd0;
        end
      end
    end else begin
      if (result.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item.valid) begin
            case (item.payload.operation) inside
              OP_BOND: begin
                state <= S_PREP;
              end
              OP_READ_FORCE, OP_READ_ENERGY, OP_READ_VIRIAL: begin
                state <= S_GRD;
              end
              OP_CLEAR: begin
                state   <= S_CLEAR;
                clr_cnt <= '0;
                for (int a = 0; a < 3; a++) begin
                  for (int b = 0; b < 3; b++) begin
                    virial[a][b] <= 64'sd0;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_CLEAR: begin
          clr_cnt <= clr_cnt + CW'(1);
          if (clr_cnt == CW'(CLR_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_PREP: begin
          state <= S_SUM;
        end
        S_SUM: begin
          state <= S_SQRT;
        end
        S_SQRT: begin
          if (sq_done) begin
            state <= S_DIVGO;
          end
        end
        S_DIVGO: begin
          step   <= MS_M;
          issued <= 1'b0;
          vrow   <= 2'd0;
          vcol   <= 2'd0;
          state  <= (dlen == 32'd0) ? S_MUL : S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (mul_start) begin
            issued <= 1'b1;
          end
          if (mul_done) begin
            issued <= 1'b0;
            step   <= step + 5'd1;
            if (step > MS_FZ && step < MS_DSQ) begin
              virial[vrow][vcol] <= sat_add64(virial[vrow][vcol], mul_res);
              if (vcol == 2'd2) begin
                vcol <= 2'd0;
                vrow <= vrow + 2'd1;
              end else begin
                vcol <= vcol + 2'd1;
              end
            end
            if (step == MS_EL) begin
              state <= S_GRD;
            end
          end
        end
        S_GRD: begin
          state <= (itm.operation == OP_BOND) ? S_GWR : S_RRESP;
        end
        S_GWR: begin
          state <= S_FRD_I;
        end
        S_FRD_I: begin
          state <= S_FWR_I;
        end
        S_FWR_I: begin
          state <= S_FRD_J;
        end
        S_FRD_J: begin
          state <= S_FWR_J;
        end
        S_FWR_J: begin
          state <= S_IDLE;
        end
        S_RRESP: begin
          if (!res_valid || result.ready) begin
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && item.valid) begin
      itm <= item.payload;
    end
    if (state == S_PREP) begin
      for (int k = 0; k < 3; k++) begin
        sq[k] <= vmag[k] * vmag[k];
      end
      bl_k0 <= (LAMBDA_ONE - lam_eff) * itm.stiffness_a;
      bl_k1 <= lam_eff * itm.stiffness_b;
      bl_r0 <= (LAMBDA_ONE - lam_eff) * itm.rest_a;
      bl_r1 <= lam_eff * itm.rest_b;
    end
    if (state == S_SUM) begin
      stiff <= ksum[47:16];
      rest  <= rsum[46:16];
    end
    if (state == S_SQRT && sq_done) begin
      dlen <= sq_root;
    end
    if (state == S_DIVGO) begin
      diff <= $signed({1'b0, dlen}) - $signed({2'b0, rest});
      for (int k = 0; k < 3; k++) begin
        u[k] <= 32'sd0;
      end
    end
    if (state == S_DIV && div_done) begin
      for (int k = 0; k < 3; k++) begin
        u[k] <= v[k][31] ? -$signed({1'b0, div_q[k]}) : $signed({1'b0, div_q[k]});
      end
    end
    if (state == S_MUL && mul_done) begin
      case (step)
        MS_M:    m       <= mul_res;
        MS_FX:   f[0]    <= -mul_res;
        MS_FY:   f[1]    <= -mul_res;
        MS_FZ:   f[2]    <= -mul_res;
        MS_DSQ:  dsq     <= mul_res;
        MS_E:    e_term  <= mul_res;
        MS_T1:   t1      <= mul_res;
        MS_T2:   t2      <= mul_res;
        MS_EL:   el_term <= mul_res;
        default: begin
        end
      endcase
    end
    if (state == S_RRESP && (!res_valid || result.ready)) begin
      res_data <= res_next;
    end
  end

endmodule

`default_nettype wire
